@@ hw/rtl/dam_pkg.sv @@
`default_nettype none
package dam_pkg;

   // Default sizes of the store and of the arithmetic word
   localparam int MEM_WORDS_DEF = 100;
   localparam int WORD_BITS_DEF = 32;

   // Fixed field widths of the stream channels
   localparam int PC_BITS       = 7;
   localparam int IO_WORD_BITS  = 32;
   localparam int EXT_BITS      = 64;
   localparam int STATUS_BITS   = 3;
   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 88;

   // Decimal split of an instruction word: word / 100 through a reciprocal
   localparam int SPLIT_BITS = 14;
   localparam int DEC_LIMIT  = 10000;
   localparam int DEC_RECIP  = 5243;
   localparam int DEC_SHIFT  = 19;
   localparam int DEC_RADIX  = 100;

   // Opcodes
   localparam logic [PC_BITS-1:0] OP_NONE   = 7'd0;
   localparam logic [PC_BITS-1:0] OP_READ   = 7'd10;
   localparam logic [PC_BITS-1:0] OP_WRITE  = 7'd11;
   localparam logic [PC_BITS-1:0] OP_LOAD   = 7'd20;
   localparam logic [PC_BITS-1:0] OP_STORE  = 7'd21;
   localparam logic [PC_BITS-1:0] OP_ADD    = 7'd30;
   localparam logic [PC_BITS-1:0] OP_SUB    = 7'd31;
   localparam logic [PC_BITS-1:0] OP_DIV    = 7'd32;
   localparam logic [PC_BITS-1:0] OP_MUL    = 7'd33;
   localparam logic [PC_BITS-1:0] OP_BRANCH = 7'd40;
   localparam logic [PC_BITS-1:0] OP_BRNEG  = 7'd41;
   localparam logic [PC_BITS-1:0] OP_BRZERO = 7'd42;
   localparam logic [PC_BITS-1:0] OP_HALT   = 7'd43;

   // Item kinds on the request tuser
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_STEP = 1'b1;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK       = 3'd0,
      ST_HALT     = 3'd1,
      ST_BAD_OP   = 3'd2,
      ST_DIV_ZERO = 3'd3,
      ST_HALTED   = 3'd4,
      ST_PC_OVF   = 3'd5,
      ST_LOADED   = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_cmd_type;

   typedef enum logic [2:0] {
      A_IDLE,
      A_MUL,
      A_DIV,
      A_SIGN,
      A_DONE
   } alu_state_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_SPLIT,
      S_OPER,
      S_EXEC,
      S_WAIT,
      S_DONE
   } seq_state_type;

endpackage
`default_nettype wire

@@ hw/rtl/dam_ram.sv @@
`default_nettype none
module dam_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 100
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word with a registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ hw/rtl/dam_alu.sv @@
`default_nettype none
module dam_alu #(
   parameter int WORD_BITS = dam_pkg::WORD_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dam_pkg::alu_cmd_type  cmd,
   input  wire logic [WORD_BITS-1:0]  opa,
   input  wire logic [WORD_BITS-1:0]  opb,
   output logic                       done,
   output logic      [WORD_BITS-1:0]  result
);

   localparam int CNT_W = $clog2(WORD_BITS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

   dam_pkg::alu_state_type state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [WORD_BITS:0]   work_ff, work_in;
   logic [WORD_BITS-1:0] aux_ff, aux_in;
   logic [WORD_BITS-1:0] opd_ff, opd_in;
   logic                 neg_ff, neg_in;
   logic [WORD_BITS-1:0] result_ff, result_in;

   logic [WORD_BITS:0]   add_x, add_y, add_sum;
   logic                 add_sub;
   logic [WORD_BITS-1:0] mag_a, mag_b;
   logic                 div_ge;

   // Shared adder: every operation of the unit goes through it
   always_comb begin
      add_x   = '0;
      add_y   = '0;
      add_sub = 1'b0;
      case (state_ff)
         dam_pkg::A_IDLE: begin
            add_x   = {1'b0, opa};
            add_y   = {1'b0, opb};
            add_sub = (cmd.op == dam_pkg::ALU_SUB);
         end
         dam_pkg::A_MUL: begin
            add_x = work_ff;
            add_y = {1'b0, opd_ff};
         end
         dam_pkg::A_DIV: begin
            add_x   = {work_ff[WORD_BITS-1:0], aux_ff[WORD_BITS-1]};
            add_y   = {1'b0, opd_ff};
            add_sub = 1'b1;
         end
         dam_pkg::A_SIGN: begin
            add_y   = {1'b0, aux_ff};
            add_sub = neg_ff;
         end
         default: begin
            add_x = '0;
         end
      endcase
      add_sum = add_x + (add_sub ? ~add_y : add_y) + (WORD_BITS + 1)'(add_sub);
   end

   assign mag_a  = opa[WORD_BITS-1] ? (~opa + 1'b1) : opa;
   assign mag_b  = opb[WORD_BITS-1] ? (~opb + 1'b1) : opb;
   assign div_ge = ~add_sum[WORD_BITS];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dam_pkg::A_IDLE: begin
            if (cmd.start) begin
               case (cmd.op)
                  dam_pkg::ALU_MUL: state_in = dam_pkg::A_MUL;
                  dam_pkg::ALU_DIV: state_in = dam_pkg::A_DIV;
                  default:          state_in = dam_pkg::A_DONE;
               endcase
            end
         end
         dam_pkg::A_MUL: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = dam_pkg::A_DONE;
            end
         end
         dam_pkg::A_DIV: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = dam_pkg::A_SIGN;
            end
         end
         dam_pkg::A_SIGN: state_in = dam_pkg::A_DONE;
         dam_pkg::A_DONE: state_in = dam_pkg::A_IDLE;
         default:         state_in = dam_pkg::A_IDLE;
      endcase
   end

   // Datapath: shift-add multiply, restoring divide, one bit a cycle
   always_comb begin
      cnt_in    = cnt_ff;
      work_in   = work_ff;
      aux_in    = aux_ff;
      opd_in    = opd_ff;
      neg_in    = neg_ff;
      result_in = result_ff;
      case (state_ff)
         dam_pkg::A_IDLE: begin
            cnt_in = '0;
            case (cmd.op)
               dam_pkg::ALU_MUL: begin
                  work_in = '0;
                  opd_in  = opa;
                  aux_in  = opb;
               end
               dam_pkg::ALU_DIV: begin
                  work_in = '0;
                  aux_in  = mag_a;
                  opd_in  = mag_b;
                  neg_in  = opa[WORD_BITS-1] ^ opb[WORD_BITS-1];
               end
               default: begin
                  result_in = add_sum[WORD_BITS-1:0];
               end
            endcase
         end
         dam_pkg::A_MUL: begin
            cnt_in = cnt_ff + 1'b1;
            if (aux_ff[0]) begin
               work_in = {1'b0, add_sum[WORD_BITS-1:0]};
            end
            aux_in    = aux_ff >> 1;
            opd_in    = opd_ff << 1;
            result_in = work_in[WORD_BITS-1:0];
         end
         dam_pkg::A_DIV: begin
            cnt_in  = cnt_ff + 1'b1;
            work_in = div_ge ? add_sum : add_x;
            aux_in  = {aux_ff[WORD_BITS-2:0], div_ge};
         end
         dam_pkg::A_SIGN: begin
            result_in = add_sum[WORD_BITS-1:0];
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   // Outputs
   always_comb begin
      done   = (state_ff == dam_pkg::A_DONE);
      result = result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dam_pkg::A_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      work_ff   <= work_in;
      aux_ff    <= aux_in;
      opd_ff    <= opd_in;
      neg_ff    <= neg_in;
      result_ff <= result_in;
   end

endmodule
`default_nettype wire

@@ hw/rtl/decimal_accumulator_machine.sv @@
`default_nettype none
// Channel   Ports       Content (low bit first)
// req       req_t*      tuser: kind; tdata: load_address, word_in
// rsp       rsp_t*      tdata: status, write_valid, write_address, write_value,
//                              acc_value, pc_value, is_halted
//
// A load passes the idle and done states on its way to the output register. A step
// passes fetch, split, operand and execute; add, subtract, multiply and divide then wait
// on the one-bit-a-cycle shared arithmetic unit. The store is a RAM with
// one valid flip-flop per word, so reset clears it at once with no sweep.
// One item is worked at a time; a finished result waits in the output
// register and the next item is taken meanwhile.
module decimal_accumulator_machine #(
   parameter int MEM_WORDS = dam_pkg::MEM_WORDS_DEF,
   parameter int WORD_BITS = dam_pkg::WORD_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // load_address[6:0], word_in[38:7], zero [39]
   input  wire logic [dam_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // kind
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // status[2:0], write_valid[3], write_address[10:4], write_value[42:11],
   // acc_value[74:43], pc_value[81:75], is_halted[82], zero [87:83]
   output logic      [dam_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int ADDR_W = $clog2(MEM_WORDS);
   localparam int PCB    = dam_pkg::PC_BITS;
   localparam int SPB    = dam_pkg::SPLIT_BITS;
   localparam logic [PCB-1:0] MEM_LIMIT = PCB'(MEM_WORDS);

   dam_pkg::seq_state_type state_ff, state_in;

   logic signed [WORD_BITS-1:0] acc_ff, acc_in;
   logic [PCB-1:0]              pc_ff, pc_in;
   logic                        halted_ff, halted_in;
   logic [MEM_WORDS-1:0]        valid_ff, valid_in;
   logic [WORD_BITS-1:0]        win_ff, win_in;
   dam_pkg::status_type         status_ff, status_in;
   logic                        wvalid_ff, wvalid_in;
   logic [PCB-1:0]              waddr_ff, waddr_in;
   logic signed [WORD_BITS-1:0] wval_ff, wval_in;
   logic [SPB-1:0]              split_w_ff, split_w_in;
   logic [PCB-1:0]              split_q_ff, split_q_in;
   logic [PCB-1:0]              opc_ff, opc_in;
   logic [PCB-1:0]              opnd_ff, opnd_in;
   logic                                rsp_tvalid_ff, rsp_tvalid_in;
   logic [dam_pkg::RSP_DATA_BITS-1:0]   rsp_tdata_ff, rsp_tdata_in;

   logic                 req_xfer, rsp_free;
   logic [PCB-1:0]       req_addr;
   logic signed [dam_pkg::IO_WORD_BITS-1:0] req_word;
   logic [WORD_BITS-1:0] word_cast;

   logic                 ram_we, ram_re;
   logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
   logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

   logic [WORD_BITS-1:0] fetch_word, oper_word;
   logic                 fetch_small, opnd_ok, div_zero;
   logic [2*SPB-1:0]     recip_prod;
   logic [SPB-1:0]       hundreds;

   dam_pkg::alu_cmd_type alu_cmd;
   logic                 alu_done;
   logic [WORD_BITS-1:0] alu_result;

   logic signed [dam_pkg::EXT_BITS-1:0] acc_ext, wval_ext;

   // Unpack the request
   assign req_xfer  = req_tvalid & req_tready;
   assign req_addr  = req_tdata[PCB-1:0];
   assign req_word  = req_tdata[PCB +: dam_pkg::IO_WORD_BITS];
   assign word_cast = WORD_BITS'(req_word);
   assign rsp_free  = ~rsp_tvalid_ff | rsp_tready;

   // Store reads: an unwritten word reads as zero
   assign fetch_word = valid_ff[pc_ff[ADDR_W-1:0]] ? ram_rdata : '0;
   assign opnd_ok    = (opnd_ff < MEM_LIMIT);
   assign oper_word  = (opnd_ok && valid_ff[opnd_ff[ADDR_W-1:0]]) ? ram_rdata : '0;
   assign div_zero   = (oper_word == '0);

   // Decimal split: a word from 0 to 9999 gives opcode and operand, any other
   // word decodes as an unknown opcode
   assign fetch_small = ~fetch_word[WORD_BITS-1] &&
                        (fetch_word < WORD_BITS'(dam_pkg::DEC_LIMIT));
   assign recip_prod  = (2*SPB)'(fetch_word[SPB-1:0]) *
                        (2*SPB)'(dam_pkg::DEC_RECIP);
   assign hundreds    = SPB'(split_q_ff) * SPB'(dam_pkg::DEC_RADIX);

   dam_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MEM_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   dam_alu #(
      .WORD_BITS (WORD_BITS)
   ) u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (alu_cmd),
      .opa    (acc_ff),
      .opb    (oper_word),
      .done   (alu_done),
      .result (alu_result)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dam_pkg::S_IDLE: begin
            if (req_xfer) begin
               if (req_tuser == dam_pkg::KIND_STEP && !halted_ff && pc_ff < MEM_LIMIT) begin
                  state_in = dam_pkg::S_FETCH;
               end else begin
                  state_in = dam_pkg::S_DONE;
               end
            end
         end
         dam_pkg::S_FETCH: state_in = dam_pkg::S_SPLIT;
         dam_pkg::S_SPLIT: state_in = dam_pkg::S_OPER;
         dam_pkg::S_OPER:  state_in = dam_pkg::S_EXEC;
         dam_pkg::S_EXEC: begin
            case (opc_ff)
               dam_pkg::OP_ADD, dam_pkg::OP_SUB, dam_pkg::OP_MUL: begin
                  state_in = dam_pkg::S_WAIT;
               end
               dam_pkg::OP_DIV: begin
                  state_in = div_zero ? dam_pkg::S_DONE : dam_pkg::S_WAIT;
               end
               default: state_in = dam_pkg::S_DONE;
            endcase
         end
         dam_pkg::S_WAIT: begin
            if (alu_done) begin
               state_in = dam_pkg::S_DONE;
            end
         end
         dam_pkg::S_DONE: begin
            if (rsp_free) begin
               state_in = dam_pkg::S_IDLE;
            end
         end
         default: state_in = dam_pkg::S_IDLE;
      endcase
   end

   // Outputs and datapath
   always_comb begin
      req_tready    = (state_ff == dam_pkg::S_IDLE);
      acc_in        = acc_ff;
      pc_in         = pc_ff;
      halted_in     = halted_ff;
      valid_in      = valid_ff;
      win_in        = win_ff;
      status_in     = status_ff;
      wvalid_in     = wvalid_ff;
      waddr_in      = waddr_ff;
      wval_in       = wval_ff;
      split_w_in    = split_w_ff;
      split_q_in    = split_q_ff;
      opc_in        = opc_ff;
      opnd_in       = opnd_ff;
      ram_we        = 1'b0;
      ram_waddr     = opnd_ff[ADDR_W-1:0];
      ram_wdata     = win_ff;
      ram_re        = 1'b0;
      ram_raddr     = pc_ff[ADDR_W-1:0];
      alu_cmd.start = 1'b0;
      alu_cmd.op    = dam_pkg::ALU_ADD;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      acc_ext       = dam_pkg::EXT_BITS'(acc_ff);
      wval_ext      = dam_pkg::EXT_BITS'(wval_ff);

      case (state_ff)
         dam_pkg::S_IDLE: begin
            // Take an item: load a word, end a halted or out-of-range step, or fetch
            if (req_xfer) begin
               win_in    = word_cast;
               status_in = dam_pkg::ST_OK;
               wvalid_in = 1'b0;
               waddr_in  = '0;
               wval_in   = '0;
               if (req_tuser == dam_pkg::KIND_LOAD) begin
                  status_in = dam_pkg::ST_LOADED;
                  if (req_addr < MEM_LIMIT) begin
                     ram_we    = 1'b1;
                     ram_waddr = req_addr[ADDR_W-1:0];
                     ram_wdata = word_cast;
                  end
               end else if (halted_ff) begin
                  status_in = dam_pkg::ST_HALTED;
               end else if (pc_ff >= MEM_LIMIT) begin
                  status_in = dam_pkg::ST_PC_OVF;
                  halted_in = 1'b1;
               end else begin
                  ram_re = 1'b1;
               end
            end
         end
         dam_pkg::S_FETCH: begin
            // Hold the fetched word and its hundreds, and advance the PC
            pc_in = pc_ff + 1'b1;
            if (fetch_small) begin
               split_w_in = fetch_word[SPB-1:0];
               split_q_in = PCB'(recip_prod >> dam_pkg::DEC_SHIFT);
            end else begin
               split_w_in = '0;
               split_q_in = dam_pkg::OP_NONE;
            end
         end
         dam_pkg::S_SPLIT: begin
            opc_in  = split_q_ff;
            opnd_in = PCB'(split_w_ff - hundreds);
         end
         dam_pkg::S_OPER: begin
            ram_re    = 1'b1;
            ram_raddr = opnd_ff[ADDR_W-1:0];
         end
         dam_pkg::S_EXEC: begin
            case (opc_ff)
               dam_pkg::OP_READ: begin
                  ram_we    = opnd_ok;
                  ram_wdata = win_ff;
               end
               dam_pkg::OP_WRITE: begin
                  wvalid_in = 1'b1;
                  waddr_in  = opnd_ff;
                  wval_in   = oper_word;
               end
               dam_pkg::OP_LOAD: acc_in = oper_word;
               dam_pkg::OP_STORE: begin
                  ram_we    = opnd_ok;
                  ram_wdata = acc_ff;
               end
               dam_pkg::OP_ADD: begin
                  alu_cmd.start = 1'b1;
                  alu_cmd.op    = dam_pkg::ALU_ADD;
               end
               dam_pkg::OP_SUB: begin
                  alu_cmd.start = 1'b1;
                  alu_cmd.op    = dam_pkg::ALU_SUB;
               end
               dam_pkg::OP_MUL: begin
                  alu_cmd.start = 1'b1;
                  alu_cmd.op    = dam_pkg::ALU_MUL;
               end
               dam_pkg::OP_DIV: begin
                  alu_cmd.op = dam_pkg::ALU_DIV;
                  if (div_zero) begin
                     status_in = dam_pkg::ST_DIV_ZERO;
                  end else begin
                     alu_cmd.start = 1'b1;
                  end
               end
               dam_pkg::OP_BRANCH: pc_in = opnd_ff;
               dam_pkg::OP_BRNEG: begin
                  if (acc_ff[WORD_BITS-1]) begin
                     pc_in = opnd_ff;
                  end
               end
               dam_pkg::OP_BRZERO: begin
                  if (acc_ff == '0) begin
                     pc_in = opnd_ff;
                  end
               end
               dam_pkg::OP_HALT: begin
                  halted_in = 1'b1;
                  status_in = dam_pkg::ST_HALT;
               end
               default: begin
                  halted_in = 1'b1;
                  status_in = dam_pkg::ST_BAD_OP;
               end
            endcase
         end
         dam_pkg::S_WAIT: begin
            if (alu_done) begin
               acc_in = alu_result;
            end
         end
         dam_pkg::S_DONE: begin
            // Move the result into the output register once it is free
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {5'b0, halted_ff, pc_ff, acc_ext[dam_pkg::IO_WORD_BITS-1:0],
                                wval_ext[dam_pkg::IO_WORD_BITS-1:0], waddr_ff, wvalid_ff,
                                status_ff};
            end
         end
         default: begin
            rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
         end
      endcase

      // Mark a written word valid
      if (ram_we) begin
         valid_in[ram_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dam_pkg::S_IDLE;
         acc_ff        <= '0;
         pc_ff         <= '0;
         halted_ff     <= 1'b0;
         valid_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         acc_ff        <= acc_in;
         pc_ff         <= pc_in;
         halted_ff     <= halted_in;
         valid_ff      <= valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      win_ff       <= win_in;
      status_ff    <= status_in;
      wvalid_ff    <= wvalid_in;
      waddr_ff     <= waddr_in;
      wval_ff      <= wval_in;
      split_w_ff   <= split_w_in;
      split_q_ff   <= split_q_in;
      opc_ff       <= opc_in;
      opnd_ff      <= opnd_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
`default_nettype wire
